@@ design/lla_pkg.sv @@
// Shared constants, types and codes for the life-like automaton block.
package lla_pkg;

	localparam int ROWS = 32;
	localparam int COLS = 128;
	localparam int CELLS = ROWS * COLS;
	localparam int AW = $clog2(CELLS);
	localparam int IDX_W = 12;
	localparam int CNT_W = IDX_W + 1;
	localparam int WIN_LEN = 2 * COLS + 3;
	localparam int SWEEP_LEN = CELLS + 2 * COLS + 2;
	localparam int SW = $clog2(SWEEP_LEN + 1);
	localparam int FILL_LEN = 2 * COLS + 2;
	localparam int MASK_W = 9;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;

	localparam logic REG_BIRTH = 1'b0;
	localparam logic REG_SURVIVAL = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_ADVANCE
	} state_t;

	typedef struct packed {
		logic shift;
		logic din;
	} win_ctl_t;

endpackage

@@ design/lla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lla_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/lla_rule.sv @@
// Sliding neighborhood window and birth/survival rule for the sweep.
module lla_rule (
	input  logic                          clk,
	input  lla_pkg::win_ctl_t             ctl,
	input  logic [lla_pkg::MASK_W-1:0]    birth_mask,
	input  logic [lla_pkg::MASK_W-1:0]    survival_mask,
	output logic                          next_cell
);

	localparam int C = lla_pkg::COLS;

	logic [lla_pkg::WIN_LEN-1:0] win_q;
	logic [3:0]                  count;

	// newest bit at 0; center cell sits at COLS+1
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q <= {win_q[lla_pkg::WIN_LEN-2:0], ctl.din};
		end
	end

	always_comb begin
		count = 4'(win_q[0]) + 4'(win_q[1]) + 4'(win_q[2]) + 4'(win_q[C])
			+ 4'(win_q[C+2]) + 4'(win_q[2*C]) + 4'(win_q[2*C+1]) + 4'(win_q[2*C+2]);
		next_cell = win_q[C+1] ? survival_mask[count] : birth_mask[count];
	end

endmodule

@@ design/life_like_automaton_generation.sv @@
// Top level of the life-like cellular automaton field.
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_tvalid / s_tready    | s_tdata: operation, cell_index, cell_value
//  m_      | out       | m_tvalid / m_tready    | m_tdata: read_value, finished_operation
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data (9-bit rule mask)
//
// Write and unused requests load the result register on acceptance; reads pass through
// the READ state first (one RAM read port). An advance sweeps the field through one RAM
// read port: a window of 2*COLS+3 cells slides past the rule logic. After reset a
// clearing pass zeroes every cell of the live bank before the first request.
// One request at a time; s_tready stays low until its result is taken.
module life_like_automaton_generation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [1:0] operation, [13:2] cell_index, [14] cell_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] read_value, [2:1] finished_operation
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int AW = lla_pkg::AW;

	lla_pkg::state_t state_q, state_d;

	logic [1:0]              in_op;
	logic [lla_pkg::IDX_W-1:0] in_idx;
	logic                    in_val;
	logic                    idx_ok;
	logic                    accept;

	logic [8:0]              birth_q, survival_q;
	logic                    sel_q;
	logic                    idx_ok_q;
	logic                    out_vld_q, rd_val_q;
	logic [1:0]              fin_op_q;

	logic [lla_pkg::SW-1:0]  t_q;
	logic [AW-1:0]           ra_q, wi_q;
	logic                    rd_vld_s1, cen_s1, wr_vld_s2;

	logic                    issue, sweep_done, clear_done;
	logic                    we0, we1, wdata;
	logic [AW-1:0]           waddr, raddr;
	logic                    rdata0, rdata1, rdata;
	logic                    next_cell;
	lla_pkg::win_ctl_t       win_ctl;

	// unpack the request
	assign in_op  = s_tdata[1:0];
	assign in_idx = s_tdata[13:2];
	assign in_val = s_tdata[14];
	assign idx_ok = lla_pkg::CNT_W'(in_idx) < lla_pkg::CNT_W'(lla_pkg::CELLS);
	assign accept = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {5'b0, fin_op_q, rd_val_q};

	// sweep bookkeeping
	assign issue      = (state_q == lla_pkg::ST_ADVANCE)
		&& (t_q != lla_pkg::SW'(lla_pkg::SWEEP_LEN));
	assign sweep_done = wr_vld_s2 && (wi_q == AW'(lla_pkg::CELLS - 1));
	assign clear_done = (state_q == lla_pkg::ST_CLEAR) && (wi_q == AW'(lla_pkg::CELLS - 1));
	assign rdata      = sel_q ? rdata1 : rdata0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lla_pkg::ST_CLEAR: begin
				if (clear_done) state_d = lla_pkg::ST_IDLE;
			end
			lla_pkg::ST_IDLE: begin
				if (accept && in_op == lla_pkg::OP_READ) state_d = lla_pkg::ST_READ;
				else if (accept && in_op == lla_pkg::OP_ADVANCE) state_d = lla_pkg::ST_ADVANCE;
			end
			lla_pkg::ST_READ: state_d = lla_pkg::ST_IDLE;
			lla_pkg::ST_ADVANCE: begin
				if (sweep_done) state_d = lla_pkg::ST_IDLE;
			end
			default: state_d = lla_pkg::ST_IDLE;
		endcase
	end

	// memory port control per state
	always_comb begin
		s_tready = 1'b0;
		wdata    = 1'b0;
		waddr    = wi_q;
		raddr    = ra_q;
		we0      = 1'b0;
		we1      = 1'b0;
		case (state_q)
			lla_pkg::ST_CLEAR: begin
				// clear the live bank, zero data
				we0 = !sel_q;
				we1 = sel_q;
			end
			lla_pkg::ST_IDLE: begin
				s_tready = !out_vld_q;
				raddr    = in_idx[AW-1:0];
				waddr    = in_idx[AW-1:0];
				wdata    = in_val;
				if (accept && in_op == lla_pkg::OP_WRITE && idx_ok) begin
					we0 = !sel_q;
					we1 = sel_q;
				end
			end
			lla_pkg::ST_ADVANCE: begin
				// read the live bank, write the new generation into the other one
				wdata = next_cell;
				we0   = wr_vld_s2 && sel_q;
				we1   = wr_vld_s2 && !sel_q;
			end
			default: begin
			end
		endcase
	end

	// rule registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q    <= 9'd8;
			survival_q <= 9'd12;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lla_pkg::REG_BIRTH) birth_q <= cfg_data;
			if (cfg_index == lla_pkg::REG_SURVIVAL) survival_q <= cfg_data;
		end
	end

	// control and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lla_pkg::ST_CLEAR;
			sel_q     <= 1'b0;
			wi_q      <= '0;
			ra_q      <= '0;
			t_q       <= '0;
			rd_vld_s1 <= 1'b0;
			cen_s1    <= 1'b0;
			wr_vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
			idx_ok_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			cen_s1    <= issue && (t_q >= lla_pkg::SW'(lla_pkg::FILL_LEN));
			wr_vld_s2 <= rd_vld_s1 && cen_s1;

			if (state_q == lla_pkg::ST_CLEAR) begin
				wi_q <= clear_done ? '0 : wi_q + 1'b1;
			end

			if (accept) begin
				idx_ok_q <= idx_ok;
				// start the read one window-half before cell 0, wrapping linearly
				t_q  <= '0;
				ra_q <= AW'(lla_pkg::CELLS - lla_pkg::COLS - 1);
				wi_q <= '0;
			end

			if (issue) begin
				t_q  <= t_q + 1'b1;
				ra_q <= (ra_q == AW'(lla_pkg::CELLS - 1)) ? '0 : ra_q + 1'b1;
			end
			if (wr_vld_s2) begin
				wi_q <= sweep_done ? '0 : wi_q + 1'b1;
			end
			if (sweep_done) begin
				sel_q <= !sel_q;
			end

			// result register: drop when taken, load when a request completes
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if ((accept && in_op != lla_pkg::OP_READ && in_op != lla_pkg::OP_ADVANCE)
				|| state_q == lla_pkg::ST_READ || sweep_done) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			fin_op_q <= in_op;
			rd_val_q <= 1'b0;
		end
		if (state_q == lla_pkg::ST_READ) begin
			rd_val_q <= idx_ok_q && rdata;
		end
	end

	assign win_ctl.shift = rd_vld_s1;
	assign win_ctl.din   = rdata;

	lla_ram #(.WIDTH(1), .DEPTH(lla_pkg::CELLS)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata0)
	);

	lla_ram #(.WIDTH(1), .DEPTH(lla_pkg::CELLS)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata1)
	);

	lla_rule u_rule (
		.clk           (clk),
		.ctl           (win_ctl),
		.birth_mask    (birth_q),
		.survival_mask (survival_q),
		.next_cell     (next_cell)
	);

endmodule

@@ test/testbench.sv @@
// Testbench for the life-like automaton field: directed and random requests under a scoreboard.
`timescale 1ns / 100ps

module testbench;
	import lla_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 4000000;

	// One expected result: the read bit and the echoed operation code.
	typedef struct packed {
		logic       read_value;
		logic [1:0] operation;
	} cell_result_t;

	// Scoreboard: a private copy of the field and the rule, plus the pending results.
	class cell_scoreboard;
		bit           field[CELLS];
		bit [8:0]     birth;
		bit [8:0]     survival;
		cell_result_t pending[$];
		int           errors;

		function void clear();
			foreach (field[i]) field[i] = 1'b0;
			birth = 9'd8;
			survival = 9'd12;
			errors = 0;
		endfunction

		function void set_rule(logic index, bit [8:0] value);
			if (index == REG_BIRTH) birth = value;
			else survival = value;
		endfunction

		// Linear wrap: every offset taken modulo the cell count.
		function void step_generation();
			bit prev[CELLS];
			int cnt;
			int offs[8];
			prev = field;
			offs = '{CELLS - 1, 1, CELLS - COLS, COLS, CELLS - COLS - 1,
				CELLS - COLS + 1, COLS - 1, COLS + 1};
			for (int i = 0; i < CELLS; i++) begin
				cnt = 0;
				foreach (offs[k]) cnt += prev[(i + offs[k]) % CELLS];
				field[i] = prev[i] ? survival[cnt] : birth[cnt];
			end
		endfunction

		function void note_request(logic [1:0] op, logic [11:0] idx, logic val);
			cell_result_t r;
			r.read_value = 1'b0;
			r.operation = op;
			case (op)
				OP_WRITE: if (idx < CELLS) field[idx] = val;
				OP_READ: if (idx < CELLS) r.read_value = field[idx];
				OP_ADVANCE: step_generation();
				default: ;
			endcase
			pending = {pending, r};
		endfunction

		function void report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endfunction

		function void check_result(logic [7:0] data);
			cell_result_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h", data));
				return;
			end
			e = pending.pop_front();
			if (data[2:1] !== e.operation)
				report($sformatf("operation %0d, want %0d", data[2:1], e.operation));
			if (data[0] !== e.read_value)
				report($sformatf("read_value %b, want %b (op %0d)", data[0],
					e.read_value, e.operation));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [1:0] operation, [13:2] cell_index, [14] cell_value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [0] read_value, [2:1] finished_operation
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [8:0]  cfg_data = '0;

	cell_scoreboard board = new();
	int send_gap_pct;
	int stall_pct;
	int hold_off;
	int cycles;

	life_like_automaton_generation DUT (.*);

	always #1 clk = ~clk;

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off for a long stretch when asked.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			m_tready = 1'b0;
		end else
			m_tready = ($urandom_range(99) >= stall_pct);
	end

	// Check every accepted result against the oldest expectation.
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);

	// Offer one request; hold it until accepted, then maybe drop valid for a gap.
	task automatic send(logic [1:0] op, logic [11:0] idx, logic val);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {1'b0, val, idx, op};
		do @(posedge clk); while (!s_tready);
		board.note_request(op, idx, val);
		if ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(6)) @(negedge clk);
		end
	endtask

	// Pause the sender until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write one rule mask while the block is idle.
	task automatic write_rule(logic index, logic [8:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		board.set_rule(index, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly writes and reads, now and then an advance or an unused code.
	task automatic random_requests(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) send(OP_WRITE, 12'($urandom), 1'($urandom));
			else if (pick < 85) send(OP_READ, 12'($urandom), 1'($urandom));
			else if (pick < 95) send(OP_ADVANCE, 12'($urandom), 1'($urandom));
			else send(OP_UNUSED, 12'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		board.clear();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field corners, a glider across the row seam, wrap at the end.
		send(OP_READ, 12'd0, 1'b0);
		send(OP_WRITE, 12'd0, 1'b1);
		send(OP_WRITE, 12'(CELLS - 1), 1'b1);
		send(OP_WRITE, 12'(CELLS - 2), 1'b1);
		send(OP_WRITE, 12'(COLS - 1), 1'b1);
		send(OP_WRITE, 12'(COLS), 1'b1);
		send(OP_WRITE, 12'(2 * COLS + 1), 1'b1);
		send(OP_WRITE, 12'(2 * COLS), 1'b1);
		send(OP_WRITE, 12'(2 * COLS - 1), 1'b1);
		send(OP_WRITE, 12'hAAA, 1'b1);
		send(OP_WRITE, 12'hAAA, 1'b0);
		send(OP_READ, 12'(CELLS - 1), 1'b1);
		send(OP_READ, 12'hAAA, 1'b0);
		send(OP_UNUSED, 12'hFFF, 1'b1);
		send(OP_ADVANCE, 12'd0, 1'b0);
		send(OP_READ, 12'd0, 1'b0);
		send(OP_READ, 12'(COLS), 1'b0);
		send(OP_READ, 12'(2 * COLS), 1'b0);
		send(OP_ADVANCE, 12'hFFF, 1'b1);
		send(OP_READ, 12'(2 * COLS), 1'b0);
		send(OP_READ, 12'(CELLS - 1), 1'b0);
		drain();

		// Phase 1: no idling, rule of extremes: everything born, everything survives.
		send_gap_pct = 0; stall_pct = 0;
		write_rule(REG_BIRTH, 9'h1FF);
		write_rule(REG_SURVIVAL, 9'h1FF);
		random_requests(30);
		drain();

		// Phase 2: sender idles; empty rule clears the field on advance.
		send_gap_pct = 64; stall_pct = 0;
		write_rule(REG_BIRTH, 9'h000);
		write_rule(REG_SURVIVAL, 9'h000);
		random_requests(30);
		drain();

		// Phase 3: receiver stalls, with one long hold-off while requests keep coming.
		send_gap_pct = 0; stall_pct = 64;
		write_rule(REG_BIRTH, 9'($urandom));
		write_rule(REG_SURVIVAL, 9'($urandom));
		hold_off = 400;
		random_requests(30);
		drain();

		// Phase 4: both sides idle a little, back to the usual rule.
		send_gap_pct = 16; stall_pct = 16;
		write_rule(REG_BIRTH, 9'd8);
		write_rule(REG_SURVIVAL, 9'd12);
		random_requests(30);
		drain();

		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
